### rtl/core/tocc_pkg.sv
// Shared types and constants for the timed output channel controller.
// Depends on nothing; every other file of the block imports it.
package tocc_pkg;

  localparam int CHANNELS    = 4;
  localparam int TIMER_BITS  = 26;
  localparam int RUN_DEFAULT = 0;
  localparam int SEC_W       = 16;
  localparam int TPS_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int PROD_W      = SEC_W + TPS_W;
  // one spare bit so that saturation of a sum or product can be seen
  localparam int CALC_W      = ((PROD_W > TIMER_BITS) ? PROD_W : TIMER_BITS) + 1;
  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_POLARITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TPS      = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    OP_CMD     = 3'd0,
    OP_TICK    = 3'd1,
    OP_HB_ODD  = 3'd2,
    OP_HB_EVEN = 3'd3,
    OP_SHORT   = 3'd4,
    OP_LONG    = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    CMD_STATUS         = 5'd0,
    CMD_ON             = 5'd1,
    CMD_OFF            = 5'd2,
    CMD_TOGGLE         = 5'd3,
    CMD_ON_LOCKED      = 5'd4,
    CMD_OFF_LOCKED     = 5'd5,
    CMD_LOCK           = 5'd6,
    CMD_UNLOCK         = 5'd7,
    CMD_ON_DELAYED     = 5'd8,
    CMD_OFF_DELAYED    = 5'd9,
    CMD_TOGGLE_DELAYED = 5'd10,
    CMD_ON_TIMED       = 5'd11,
    CMD_OFF_TIMED      = 5'd12,
    CMD_TOGGLE_TIMED   = 5'd13,
    CMD_LOCK_TIMED     = 5'd14,
    CMD_TIMER_ADD      = 5'd15,
    CMD_TIMER_SET      = 5'd16,
    CMD_TIMER_ABORT    = 5'd17,
    CMD_BLINK          = 5'd18,
    CMD_BLINK_TIMED    = 5'd19,
    CMD_SET_DEFAULT    = 5'd20
  } cmd_t;

  typedef enum logic [3:0] {
    PA_NONE           = 4'd0,
    PA_ON_DELAYED     = 4'd1,
    PA_OFF_DELAYED    = 4'd2,
    PA_TOGGLE_DELAYED = 4'd3,
    PA_ON_TIMED       = 4'd4,
    PA_OFF_TIMED      = 4'd5,
    PA_TOGGLE_TIMED   = 4'd6,
    PA_LOCK_TIMED     = 4'd7,
    PA_BLINK          = 4'd8,
    PA_BLINK_TIMED    = 4'd9
  } pa_t;

  // decoded request as seen by every channel
  typedef struct packed {
    op_t              op;
    logic             sel;
    cmd_t             code;
    logic [SEC_W-1:0] sec;
    logic             wr;
    logic             autor;
    logic [TPS_W-1:0] tps;
  } chan_req_t;

  typedef struct packed {
    logic             on_q;
    logic             on_next;
    logic             rsp_valid;
    logic [SEC_W-1:0] rsp;
    logic             err;
  } chan_res_t;

endpackage

### rtl/core/tocc_ifs.sv
// Handshake channel interfaces: request, result and register write.
// Depends on tocc_pkg.
interface tocc_req_if import tocc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [2:0]       opcode;
  logic [1:0]       channel;
  logic [4:0]       command_code;
  logic [SEC_W-1:0] seconds;
  logic             write_default;
  logic             auto_response;

  modport source (output valid, opcode, channel, command_code, seconds, write_default,
                  auto_response, input ready);
  modport sink (input valid, opcode, channel, command_code, seconds, write_default,
                auto_response, output ready);
endinterface

interface tocc_res_if import tocc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [3:0]       pin_levels;
  logic [3:0]       channel_states;
  logic [3:0]       changed_mask;
  logic [SEC_W-1:0] response;
  logic             response_valid;
  logic             error;

  modport source (output valid, pin_levels, channel_states, changed_mask, response,
                  response_valid, error, input ready);
  modport sink (input valid, pin_levels, channel_states, changed_mask, response,
                response_valid, error, output ready);
endinterface

interface tocc_cfg_if import tocc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/tocc_chan.sv
// One output channel: state, lock, pending action, tick timer, blink default.
// Next state is formed from the request held in the input register.
// Depends on tocc_pkg.
module tocc_chan import tocc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  chan_req_t req,
  output chan_res_t res
);

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic                  on, on_next;
  pa_t                   pa, pa_next;
  logic                  lk, lk_next;
  logic                  armed, armed_next;
  logic [TIMER_BITS-1:0] tl, tl_next;
  logic [SEC_W-1:0]      bd, bd_next;

  cmd_t                  code_e;
  logic [SEC_W-1:0]      sec_e;
  logic [CALC_W-1:0]     prod, sum;
  logic [TIMER_BITS-1:0] sec_ticks, add_ticks, tl_dec;
  logic                  rsp_valid, err;
  logic [SEC_W-1:0]      rsp;

  // press requests map onto toggle and blink
  always_comb begin
    code_e = req.code;
    sec_e  = req.sec;
    if (req.op == OP_SHORT) begin
      code_e = CMD_TOGGLE;
      sec_e  = '0;
    end else if (req.op == OP_LONG) begin
      code_e = (bd != '0) ? CMD_BLINK_TIMED : CMD_BLINK;
      sec_e  = bd;
    end
  end

  assign prod      = CALC_W'(sec_e) * CALC_W'(req.tps);
  assign sec_ticks = (prod > CALC_W'(TMAX)) ? TMAX : prod[TIMER_BITS-1:0];
  assign sum       = CALC_W'(tl) + CALC_W'(sec_ticks);
  assign add_ticks = (sum > CALC_W'(TMAX)) ? TMAX : sum[TIMER_BITS-1:0];
  assign tl_dec    = (tl != '0) ? tl - TIMER_BITS'(1) : tl;

  always_comb begin
    on_next    = on;
    pa_next    = pa;
    lk_next    = lk;
    armed_next = armed;
    tl_next    = tl;
    bd_next    = bd;
    rsp        = '0;
    rsp_valid  = 1'b0;
    err        = 1'b0;
    case (req.op)
      OP_CMD, OP_SHORT, OP_LONG: begin
        if (req.sel) begin
          case (code_e)
            CMD_STATUS: begin
              rsp       = SEC_W'(on);
              rsp_valid = 1'b1;
            end
            CMD_ON, CMD_OFF: begin
              if (!lk) begin
                pa_next = PA_NONE;
                on_next = (code_e == CMD_ON);
              end
            end
            CMD_TOGGLE: begin
              if (!lk) begin
                pa_next = PA_NONE;
                on_next = !on;
              end
            end
            CMD_ON_LOCKED, CMD_OFF_LOCKED: begin
              if (!lk) begin
                pa_next = PA_NONE;
                lk_next = 1'b1;
                on_next = (code_e == CMD_ON_LOCKED);
              end
            end
            CMD_LOCK:   lk_next = 1'b1;
            CMD_UNLOCK: lk_next = 1'b0;
            CMD_ON_DELAYED, CMD_OFF_DELAYED: begin
              if (!lk) begin
                pa_next    = (code_e == CMD_ON_DELAYED) ? PA_ON_DELAYED : PA_OFF_DELAYED;
                armed_next = 1'b1;
                tl_next    = sec_ticks;
              end
            end
            CMD_TOGGLE_DELAYED: begin
              if (!lk) begin
                pa_next    = PA_TOGGLE_DELAYED;
                armed_next = 1'b1;
                tl_next    = sec_ticks;
                lk_next    = 1'b1;
              end
            end
            CMD_ON_TIMED, CMD_OFF_TIMED: begin
              if (!lk) begin
                pa_next    = (code_e == CMD_ON_TIMED) ? PA_ON_TIMED : PA_OFF_TIMED;
                armed_next = 1'b1;
                tl_next    = sec_ticks;
                on_next    = (code_e == CMD_ON_TIMED);
              end
            end
            CMD_TOGGLE_TIMED: begin
              if (!lk) begin
                pa_next    = PA_TOGGLE_TIMED;
                armed_next = 1'b1;
                tl_next    = sec_ticks;
                lk_next    = 1'b1;
                on_next    = 1'b1;
              end
            end
            CMD_LOCK_TIMED: begin
              if (!lk && armed) begin
                lk_next = 1'b1;
                pa_next = PA_LOCK_TIMED;
              end
            end
            CMD_TIMER_ADD: begin
              if (armed) tl_next = add_ticks;
            end
            CMD_TIMER_SET: begin
              armed_next = 1'b1;
              tl_next    = sec_ticks;
            end
            CMD_TIMER_ABORT: begin
              pa_next    = PA_NONE;
              armed_next = 1'b0;
              tl_next    = '0;
            end
            CMD_BLINK: begin
              if (!lk) begin
                pa_next = PA_BLINK;
                on_next = !on;
              end
            end
            CMD_BLINK_TIMED: begin
              if (!lk) begin
                pa_next    = PA_BLINK_TIMED;
                armed_next = 1'b1;
                tl_next    = sec_ticks;
                on_next    = !on;
              end
            end
            CMD_SET_DEFAULT: begin
              bd_next   = req.wr ? req.sec : bd;
              rsp       = req.wr ? req.sec : bd;
              rsp_valid = 1'b1;
            end
            default: err = (req.op == OP_CMD);
          endcase
          if (req.op == OP_CMD && req.autor) begin
            rsp       = SEC_W'(on_next);
            rsp_valid = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (armed) begin
          tl_next = tl_dec;
          // expiry; with no timed action the timer stays armed at zero
          if (tl_dec == '0) begin
            case (pa)
              PA_ON_DELAYED, PA_OFF_TIMED: begin
                on_next    = 1'b1;
                pa_next    = PA_NONE;
                armed_next = 1'b0;
              end
              PA_OFF_DELAYED, PA_ON_TIMED, PA_BLINK_TIMED: begin
                on_next    = 1'b0;
                pa_next    = PA_NONE;
                armed_next = 1'b0;
              end
              PA_TOGGLE_DELAYED, PA_TOGGLE_TIMED: begin
                on_next    = !on;
                pa_next    = PA_NONE;
                armed_next = 1'b0;
                lk_next    = 1'b0;
              end
              PA_LOCK_TIMED: begin
                pa_next    = PA_NONE;
                armed_next = 1'b0;
                lk_next    = 1'b0;
              end
              default: ;
            endcase
          end
        end
      end
      OP_HB_ODD, OP_HB_EVEN: begin
        if (pa == PA_BLINK || pa == PA_BLINK_TIMED) on_next = (req.op == OP_HB_ODD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on    <= 1'b0;
      pa    <= PA_NONE;
      lk    <= 1'b0;
      armed <= 1'b0;
      tl    <= '0;
      bd    <= SEC_W'(RUN_DEFAULT);
    end else if (step) begin
      on    <= on_next;
      pa    <= pa_next;
      lk    <= lk_next;
      armed <= armed_next;
      tl    <= tl_next;
      bd    <= bd_next;
    end
  end

  assign res.on_q      = on;
  assign res.on_next   = on_next;
  assign res.rsp_valid = rsp_valid;
  assign res.rsp       = rsp;
  assign res.err       = err;

endmodule

### rtl/core/timed_output_channel_controller.sv
// Timed output channel controller: four on/off outputs with polarity,
// locks, tick-counted timers and blinking.
//
// Channels: req carries command, tick, heartbeat and press requests;
// res returns one result per request (pin levels, states, changed mask,
// response, error); cfg writes polarity_mask (index 0) and
// ticks_per_second (index 1), always ready, to be used while idle.
// A request passes the input register, then the result register, to res.
// One request per cycle while res.ready does not stall the result register;
// all channels update in parallel in the single logic pass between the
// two registers, whose longest path is the 16 x 10 seconds-to-ticks
// multiply and the timer-add saturation.
// Reset (rst, synchronous): all channels off, unlocked, no pending action,
// timers clear, blink defaults at the run default, polarity 0,
// 1000 ticks per second; both registers empty.
// Receiver stall: the result register holds; the input register still
// takes one more request, then req.ready drops until res.ready returns.
// Depends on tocc_pkg, tocc_ifs and tocc_chan.
module timed_output_channel_controller import tocc_pkg::*; (
  input logic       clk,
  input logic       rst,
  tocc_req_if.sink  req,
  tocc_res_if.source res,
  tocc_cfg_if.sink  cfg
);

  logic [3:0]       polarity;
  logic [TPS_W-1:0] tps;

  logic             s1_valid;
  op_t              s1_op;
  logic [1:0]       s1_ch;
  cmd_t             s1_code;
  logic [SEC_W-1:0] s1_sec;
  logic             s1_wr;
  logic             s1_autor;

  logic             o_valid;
  logic [3:0]       o_pins, o_states, o_changed;
  logic [SEC_W-1:0] o_rsp;
  logic             o_rsp_valid, o_err;

  logic                adv;
  chan_req_t           creq [CHANNELS];
  chan_res_t           cres [CHANNELS];
  logic [CHANNELS-1:0] prior, after, rv_vec, err_vec;
  logic [SEC_W-1:0]    rsp_or;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity <= '0;
      tps      <= TPS_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_POLARITY) polarity <= cfg.data[3:0];
      else if (cfg.index == REG_TPS) tps <= cfg.data[TPS_W-1:0];
    end
  end

  assign adv       = s1_valid && (!o_valid || res.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_op    <= op_t'(req.opcode);
      s1_ch    <= req.channel;
      s1_code  <= cmd_t'(req.command_code);
      s1_sec   <= req.seconds;
      s1_wr    <= req.write_default;
      s1_autor <= req.auto_response;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    always_comb begin
      creq[c].op    = s1_op;
      creq[c].sel   = (int'(s1_ch) == c);
      creq[c].code  = s1_code;
      creq[c].sec   = s1_sec;
      creq[c].wr    = s1_wr;
      creq[c].autor = s1_autor;
      creq[c].tps   = tps;
    end

    tocc_chan u_chan (
      .clk  (clk),
      .rst  (rst),
      .step (adv),
      .req  (creq[c]),
      .res  (cres[c])
    );

    assign prior[c]   = cres[c].on_q;
    assign after[c]   = cres[c].on_next;
    assign rv_vec[c]  = cres[c].rsp_valid;
    assign err_vec[c] = cres[c].err;
  end

  // only the selected channel can answer, so an OR is the select
  always_comb begin
    rsp_or = '0;
    for (int c = 0; c < CHANNELS; c++) rsp_or = rsp_or | cres[c].rsp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_states    <= 4'(after);
      o_pins      <= 4'(after) ^ polarity;
      o_changed   <= 4'(after ^ prior);
      o_rsp       <= rsp_or;
      o_rsp_valid <= |rv_vec;
      o_err       <= |err_vec;
    end
  end

  assign res.valid          = o_valid;
  assign res.pin_levels     = o_pins;
  assign res.channel_states = o_states;
  assign res.changed_mask   = o_changed;
  assign res.response       = o_rsp;
  assign res.response_valid = o_rsp_valid;
  assign res.error          = o_err;

endmodule

### rtl/core/tocc_checker.sv
// Port-level checks on the result channel of the controller, and the bind
// that attaches them to the top level. Depends on tocc_pkg.
module tocc_checker import tocc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [3:0]       states,
  input logic [3:0]       changed,
  input logic [SEC_W-1:0] response,
  input logic             response_valid,
  input logic             error
);

  logic [3:0] last_states;

  // states as of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_states <= '0;
    end else if (out_valid && out_ready) begin
      last_states <= states;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(states) && $stable(response))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (states ^ changed) == last_states)
    else $error("changed mask does not link to previous states");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> changed == 4'd0)
    else $error("unknown command changed a channel");

  a_rsp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !response_valid |-> response == '0)
    else $error("response nonzero without response_valid");

endmodule

bind timed_output_channel_controller tocc_checker u_tocc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .states         (res.channel_states),
  .changed        (res.changed_mask),
  .response       (res.response),
  .response_valid (res.response_valid),
  .error          (res.error)
);

### sim/timed_output_channel_controller_tb.sv
`timescale 1ns / 100ps
// Testbench for timed_output_channel_controller: a directed table, then random requests
// checked against a cycle-free channel predictor. Depends on tocc_pkg and tocc_ifs.
module timed_output_channel_controller_tb;
  import tocc_pkg::*;

  localparam int          LIMIT_CYCLES    = 400000;
  localparam int          SEGMENTS        = 6;
  localparam int          SEGMENT_ITEMS   = 320;
  localparam int          SETTLE_CYCLES   = 4;
  localparam logic [2:0]  OP_SPARE6       = 3'd6;
  localparam logic [2:0]  OP_SPARE7       = 3'd7;
  localparam logic [4:0]  CMD_FIRST_UNKNOWN = 5'd21;
  localparam logic [4:0]  CMD_UNKNOWN_TOP = 5'd31;
  localparam logic [63:0] TIMER_TOP       = (64'd1 << TIMER_BITS) - 64'd1;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [1:0]       channel;
    logic [4:0]       code;
    logic [SEC_W-1:0] seconds;
    logic             wr;
    logic             autor;
  } request_t;

  typedef struct packed {
    logic [3:0]       pins;
    logic [3:0]       states;
    logic [3:0]       changed;
    logic [SEC_W-1:0] response;
    logic             rsp_valid;
    logic             error;
  } report_t;

  typedef struct {
    request_t req;
    bit       typed;
    report_t  want;
  } table_row_t;

  logic clk;
  logic rst;

  tocc_req_if req_if ();
  tocc_res_if res_if ();
  tocc_cfg_if cfg_if ();

  timed_output_channel_controller i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // predictor copy of the block state and registers
  logic                  ch_on        [CHANNELS];
  pa_t                   ch_pending   [CHANNELS];
  logic                  ch_locked    [CHANNELS];
  logic                  ch_armed     [CHANNELS];
  logic [TIMER_BITS-1:0] ch_ticks     [CHANNELS];
  logic [SEC_W-1:0]      ch_blink_def [CHANNELS];
  logic [3:0]            pol_mask;
  logic [TPS_W-1:0]      tick_rate;

  report_t    reports_due [$];
  table_row_t dir_rows [$];

  int send_idle_pct;
  int recv_idle_pct;
  int requests_sent;
  int reports_checked;
  int mismatches;
  int reg_writes;
  int cycles;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d reports outstanding", cycles, reports_due.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) res_if.ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [TIMER_BITS-1:0] secs_to_ticks(input logic [SEC_W-1:0] s);
    logic [63:0] p;
    p = 64'(s) * 64'(tick_rate);
    return (p > TIMER_TOP) ? TIMER_TOP[TIMER_BITS-1:0] : p[TIMER_BITS-1:0];
  endfunction

  function automatic void arm_timer(input int c, input logic [SEC_W-1:0] s);
    ch_armed[c] = 1'b1;
    ch_ticks[c] = secs_to_ticks(s);
  endfunction

  function automatic void retire(input int c);
    ch_pending[c] = PA_NONE;
    ch_armed[c]   = 1'b0;
    ch_ticks[c]   = '0;
  endfunction

  function automatic logic [3:0] state_bits();
    logic [3:0] m;
    for (int c = 0; c < CHANNELS; c++) m[c] = ch_on[c];
    return m;
  endfunction

  // returns 0 for an unknown command code
  function automatic bit run_command(input int c, input logic [4:0] code,
                                     input logic [SEC_W-1:0] sec, input logic wr,
                                     inout logic [SEC_W-1:0] rsp, inout bit rsp_ok);
    logic [63:0] sum;
    bit          held;
    held = ch_locked[c];
    case (code)
      CMD_STATUS: begin
        rsp    = SEC_W'(ch_on[c]);
        rsp_ok = 1'b1;
      end
      CMD_ON, CMD_OFF: if (!held) begin
        ch_pending[c] = PA_NONE;
        ch_on[c]      = (code == CMD_ON);
      end
      CMD_TOGGLE: if (!held) begin
        ch_pending[c] = PA_NONE;
        ch_on[c]      = ~ch_on[c];
      end
      CMD_ON_LOCKED, CMD_OFF_LOCKED: if (!held) begin
        ch_pending[c] = PA_NONE;
        ch_locked[c]  = 1'b1;
        ch_on[c]      = (code == CMD_ON_LOCKED);
      end
      CMD_LOCK:   ch_locked[c] = 1'b1;
      CMD_UNLOCK: ch_locked[c] = 1'b0;
      CMD_ON_DELAYED, CMD_OFF_DELAYED: if (!held) begin
        ch_pending[c] = (code == CMD_ON_DELAYED) ? PA_ON_DELAYED : PA_OFF_DELAYED;
        arm_timer(c, sec);
      end
      CMD_TOGGLE_DELAYED: if (!held) begin
        ch_pending[c] = PA_TOGGLE_DELAYED;
        arm_timer(c, sec);
        ch_locked[c] = 1'b1;
      end
      CMD_ON_TIMED, CMD_OFF_TIMED: if (!held) begin
        ch_pending[c] = (code == CMD_ON_TIMED) ? PA_ON_TIMED : PA_OFF_TIMED;
        arm_timer(c, sec);
        ch_on[c] = (code == CMD_ON_TIMED);
      end
      CMD_TOGGLE_TIMED: if (!held) begin
        ch_pending[c] = PA_TOGGLE_TIMED;
        arm_timer(c, sec);
        ch_locked[c] = 1'b1;
        ch_on[c]     = 1'b1;
      end
      CMD_LOCK_TIMED: if (!held && ch_armed[c]) begin
        ch_locked[c]  = 1'b1;
        ch_pending[c] = PA_LOCK_TIMED;
      end
      CMD_TIMER_ADD: if (ch_armed[c]) begin
        sum = 64'(ch_ticks[c]) + 64'(secs_to_ticks(sec));
        ch_ticks[c] = (sum > TIMER_TOP) ? TIMER_TOP[TIMER_BITS-1:0] : sum[TIMER_BITS-1:0];
      end
      CMD_TIMER_SET: arm_timer(c, sec);
      CMD_TIMER_ABORT: retire(c);
      CMD_BLINK: if (!held) begin
        ch_pending[c] = PA_BLINK;
        ch_on[c]      = ~ch_on[c];
      end
      CMD_BLINK_TIMED: if (!held) begin
        ch_pending[c] = PA_BLINK_TIMED;
        arm_timer(c, sec);
        ch_on[c] = ~ch_on[c];
      end
      CMD_SET_DEFAULT: begin
        if (wr) ch_blink_def[c] = sec;
        rsp    = ch_blink_def[c];
        rsp_ok = 1'b1;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic report_t apply_request(input request_t r);
    report_t          rep;
    logic [3:0]       was;
    logic [3:0]       now;
    logic [SEC_W-1:0] rsp;
    logic [SEC_W-1:0] d;
    bit               rsp_ok;
    bit               bad;
    int               ch;
    was    = state_bits();
    rsp    = '0;
    rsp_ok = 1'b0;
    bad    = 1'b0;
    ch     = int'(r.channel);
    case (r.opcode)
      OP_CMD: begin
        bad = !run_command(ch, r.code, r.seconds, r.wr, rsp, rsp_ok);
        if (r.autor) begin
          rsp    = SEC_W'(ch_on[ch]);
          rsp_ok = 1'b1;
        end
      end
      OP_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (ch_armed[c]) begin
            if (ch_ticks[c] != 0) ch_ticks[c]--;
            // an armed timer at zero with no timed action just sits there
            if (ch_ticks[c] == 0) begin
              case (ch_pending[c])
                PA_ON_DELAYED, PA_OFF_TIMED: begin
                  ch_on[c] = 1'b1;
                  retire(c);
                end
                PA_OFF_DELAYED, PA_ON_TIMED, PA_BLINK_TIMED: begin
                  ch_on[c] = 1'b0;
                  retire(c);
                end
                PA_TOGGLE_DELAYED, PA_TOGGLE_TIMED: begin
                  ch_on[c] = ~ch_on[c];
                  retire(c);
                  ch_locked[c] = 1'b0;
                end
                PA_LOCK_TIMED: begin
                  retire(c);
                  ch_locked[c] = 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
      end
      OP_HB_ODD, OP_HB_EVEN: begin
        for (int c = 0; c < CHANNELS; c++)
          if (ch_pending[c] == PA_BLINK || ch_pending[c] == PA_BLINK_TIMED)
            ch_on[c] = (r.opcode == OP_HB_ODD);
      end
      OP_SHORT: void'(run_command(ch, CMD_TOGGLE, '0, 1'b0, rsp, rsp_ok));
      OP_LONG: begin
        d = ch_blink_def[ch];
        void'(run_command(ch, (d != 0) ? CMD_BLINK_TIMED : CMD_BLINK, d, 1'b0, rsp, rsp_ok));
      end
      default: ;
    endcase
    now           = state_bits();
    rep.pins      = now ^ pol_mask;
    rep.states    = now;
    rep.changed   = now ^ was;
    rep.response  = rsp_ok ? rsp : '0;
    rep.rsp_valid = rsp_ok;
    rep.error     = bad;
    return rep;
  endfunction

  task automatic issue(input request_t r, input bit typed, input report_t want);
    report_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.opcode        <= r.opcode;
    req_if.channel       <= r.channel;
    req_if.command_code  <= r.code;
    req_if.seconds       <= r.seconds;
    req_if.write_default <= r.wr;
    req_if.auto_response <= r.autor;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred = apply_request(r);
    reports_due.push_back(typed ? want : pred);
    requests_sent++;
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == REG_POLARITY) pol_mask = val[3:0];
    else if (idx == REG_TPS) tick_rate = val[TPS_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic add_row(input logic [2:0] op, input logic [1:0] ch, input logic [4:0] code,
                         input logic [SEC_W-1:0] sec, input logic wr, input logic autor,
                         input bit typed, input report_t want);
    table_row_t row;
    row.req   = {op, ch, code, sec, wr, autor};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.channel = 2'($urandom_range(3));
    r.wr      = 1'($urandom_range(1));
    r.autor   = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 45)      r.opcode = OP_CMD;
    else if (pick < 80) r.opcode = OP_TICK;
    else if (pick < 86) r.opcode = OP_HB_ODD;
    else if (pick < 92) r.opcode = OP_HB_EVEN;
    else if (pick < 95) r.opcode = OP_SHORT;
    else if (pick < 98) r.opcode = OP_LONG;
    else                r.opcode = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    if ($urandom_range(99) < 95) r.code = 5'($urandom_range(CMD_SET_DEFAULT));
    else r.code = 5'($urandom_range(CMD_UNKNOWN_TOP, CMD_FIRST_UNKNOWN));
    // mostly short timers so that expiries happen; now and then a full-range value
    pick = $urandom_range(99);
    if (pick < 55)      r.seconds = SEC_W'($urandom_range(3));
    else if (pick < 90) r.seconds = SEC_W'($urandom_range(24));
    else                r.seconds = SEC_W'($urandom_range(16'hFFFF));
    return r;
  endfunction

  always @(posedge clk) begin : watch_results
    report_t got;
    report_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.pin_levels, res_if.channel_states, res_if.changed_mask,
             res_if.response, res_if.response_valid, res_if.error};
      reports_checked++;
      if (reports_due.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        if (got.pins !== want.pins)
          $display("%0t: pin_levels expected %h got %h", $time, want.pins, got.pins);
        if (got.states !== want.states)
          $display("%0t: channel_states expected %h got %h", $time, want.states, got.states);
        if (got.changed !== want.changed)
          $display("%0t: changed_mask expected %h got %h", $time, want.changed, got.changed);
        if (got.response !== want.response)
          $display("%0t: response expected %h got %h", $time, want.response, got.response);
        if (got.rsp_valid !== want.rsp_valid)
          $display("%0t: response_valid expected %b got %b", $time, want.rsp_valid,
                   got.rsp_valid);
        if (got.error !== want.error)
          $display("%0t: error expected %b got %b", $time, want.error, got.error);
        if (got !== want) mismatches++;
      end
    end
  end

  initial begin
    logic [3:0]       seg_pol;
    logic [TPS_W-1:0] seg_rate;
    clk                  = 1'b0;
    rst                  = 1'b1;
    req_if.valid         = 1'b0;
    req_if.opcode        = '0;
    req_if.channel       = '0;
    req_if.command_code  = '0;
    req_if.seconds       = '0;
    req_if.write_default = 1'b0;
    req_if.auto_response = 1'b0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    send_idle_pct        = 29;
    recv_idle_pct        = 75;
    requests_sent        = 0;
    reports_checked      = 0;
    mismatches           = 0;
    reg_writes           = 0;
    cycles               = 0;
    pol_mask             = '0;
    tick_rate            = TPS_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      ch_on[c]        = 1'b0;
      ch_pending[c]   = PA_NONE;
      ch_locked[c]    = 1'b0;
      ch_armed[c]     = 1'b0;
      ch_ticks[c]     = '0;
      ch_blink_def[c] = SEC_W'(RUN_DEFAULT);
    end

    // directed table at reset settings: polarity 0, 1000 ticks per second
    add_row(OP_CMD, 2'd0, CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b1,
            {4'h0, 4'h0, 4'h0, 16'h0000, 1'b1, 1'b0});
    add_row(OP_CMD, 2'd3, CMD_UNKNOWN_TOP, 16'hFFFF, 1'b1, 1'b1, 1'b1,
            {4'h0, 4'h0, 4'h0, 16'h0000, 1'b1, 1'b1});
    add_row(OP_CMD, 2'd0, CMD_ON, 16'h0000, 1'b0, 1'b1, 1'b1,
            {4'h1, 4'h1, 4'h1, 16'h0001, 1'b1, 1'b0});
    add_row(OP_CMD, 2'd1, CMD_SET_DEFAULT, 16'hFFFF, 1'b1, 1'b0, 1'b1,
            {4'h1, 4'h1, 4'h0, 16'hFFFF, 1'b1, 1'b0});
    add_row(OP_CMD, 2'd2, CMD_ON_LOCKED, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd2, CMD_TOGGLE, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_CMD, 2'd2, CMD_UNLOCK, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd2, CMD_OFF_LOCKED, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_LOCK, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_OFF, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_UNLOCK, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_ON_DELAYED, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd0, CMD_OFF_DELAYED, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd1, CMD_TOGGLE_DELAYED, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_TICK, 2'd0, CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_LOCK_TIMED, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_CMD, 2'd0, CMD_ON_TIMED, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
    // sum of two full-range timers saturates the counter
    add_row(OP_CMD, 2'd0, CMD_TIMER_ADD, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd0, CMD_LOCK_TIMED, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd0, CMD_TIMER_SET, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_TICK, 2'd3, CMD_UNKNOWN_TOP, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_OFF_TIMED, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd1, CMD_TOGGLE_TIMED, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_TICK, 2'd0, CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd0, CMD_BLINK, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_BLINK_TIMED, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_HB_ODD, 2'd0, CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_HB_EVEN, 2'd0, CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_CMD, 2'd3, CMD_TIMER_ABORT, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_SHORT, 2'd1, CMD_STATUS, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_LONG, 2'd1, CMD_STATUS, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_LONG, 2'd0, CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_SPARE6, 2'd2, CMD_ON, 16'h0001, 1'b1, 1'b1, 1'b0, '0);
    add_row(OP_SPARE7, 2'd3, CMD_ON, 16'h0001, 1'b1, 1'b1, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       begin seg_pol = 4'hF; seg_rate = 10'd1;    end
        1:       begin seg_pol = 4'h0; seg_rate = 10'd2;    end
        2:       begin seg_pol = 4'h5; seg_rate = 10'd0;    end
        3:       begin seg_pol = 4'hA; seg_rate = 10'd3;    end
        4:       begin seg_pol = 4'h3; seg_rate = 10'd1023; end
        default: begin seg_pol = 4'hC; seg_rate = 10'd1;    end
      endcase
      // receiver-heavy idling, then sender-heavy, then none
      if (seg < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 75;
      end else if (seg < 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      write_reg(REG_POLARITY, CFG_DATA_W'(seg_pol));
      write_reg(REG_TPS, seg_rate);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        issue(random_request(), 1'b0, '0);
        if ($urandom_range(199) == 0) settle();
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d from the table) across %0d register writes;",
             requests_sent, dir_rows.size(), reg_writes);
    $display("checked %0d results, %0d with mismatches.", reports_checked, mismatches);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tocc_pkg.sv
rtl/core/tocc_ifs.sv
rtl/core/tocc_chan.sv
rtl/core/timed_output_channel_controller.sv
rtl/core/tocc_checker.sv
sim/timed_output_channel_controller_tb.sv
